[design/mip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_pkg
// Shared constants, codes and types of the mirror I/O policy unit.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int MAX_CHILDREN = 8;
  localparam int LANE_LIMIT   = 8;
  localparam int LANES        = (MAX_CHILDREN < LANE_LIMIT) ? MAX_CHILDREN : LANE_LIMIT;
  localparam int IDX_W        = 3;
  localparam int ROTATE_SHIFT = 23;
  localparam int OFFSET_W     = 64;
  localparam int MOD_BITS     = OFFSET_W - ROTATE_SHIFT;
  localparam int MCNT_W       = $clog2(MOD_BITS + 1);

  // input commands
  localparam logic [1:0] CMD_START_READ  = 2'd0;
  localparam logic [1:0] CMD_START_WRITE = 2'd1;
  localparam logic [1:0] CMD_CHILD_DONE  = 2'd2;
  localparam logic [1:0] CMD_FINISH      = 2'd3;

  // error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_IO    = 3'd1;
  localparam logic [2:0] ERR_NODEV = 3'd2;
  localparam logic [2:0] ERR_STALE = 3'd3;
  localparam logic [2:0] ERR_OTHER = 3'd5;

  // result kinds
  localparam logic [1:0] K_READ   = 2'd0;
  localparam logic [1:0] K_WRITE  = 2'd1;
  localparam logic [1:0] K_REPAIR = 2'd2;
  localparam logic [1:0] K_DONE   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_CHILD_COUNT = 3'd0;
  localparam logic [2:0] CFG_REPLACING   = 3'd1;
  localparam logic [2:0] CFG_NO_SIBLING  = 3'd2;
  localparam logic [2:0] CFG_REPAIR_EN   = 3'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ISSUE, S_WRITE1, S_MOD_INIT, S_MOD, S_SEL_INIT,
    S_SEL1, S_SEL2, S_SEL_FAIL, S_EMIT_SEL, S_SCAN_INIT, S_SCAN, S_FIN_DEC,
    S_FIN_TAIL, S_REPAIR, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CHILD_UPD, OP_MOD_INIT, OP_MOD_STEP, OP_SEL_INIT,
    OP_SEL1, OP_SEL2, OP_SCAN_INIT, OP_SCAN, OP_ISSUE, OP_WRITE1,
    OP_EMIT_SEL, OP_REPAIR, OP_EMIT_DONE
  } op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       scrub;
    logic       write1;
    logic       cnt_end;
    logic       mod_last;
    logic       hit1;
    logic       hit2;
    logic       no_sibling;
    logic       retry;
    logic       repair_go;
    logic       rep_qual;
    logic       out_free;
  } dp_status_t;

endpackage

[design/mip_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_in_if / mip_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface mip_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        scrub;
  logic        resilver;
  logic [63:0] offset;
  logic [7:0]  dead_mask;
  logic [7:0]  stale_mask;
  logic [2:0]  child;
  logic [2:0]  child_error;

  modport source (output valid, command, scrub, resilver, offset, dead_mask,
                  stale_mask, child, child_error, input ready);
  modport sink (input valid, command, scrub, resilver, offset, dead_mask,
                stale_mask, child, child_error, output ready);
endinterface

interface mip_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] target_child;
  logic [2:0] status;
  logic [3:0] error_count;
  logic       last;

  modport source (output valid, kind, target_child, status, error_count, last,
                  input ready);
  modport sink (input valid, kind, target_child, status, error_count, last,
                output ready);
endinterface

[design/mip_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_ctrl
// Sequencer: walks each transaction through select, scan, repair and issue.
// ----------------------------------------------------------------------------
module mip_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mip_pkg::dp_status_t st,
  output mip_pkg::op_t        op
);

  mip_pkg::state_t state, state_next;
  logic            origin;  // 1 when selection was entered from a finish

  // state and origin registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mip_pkg::S_IDLE;
      origin <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mip_pkg::S_DISPATCH) origin <= 1'b0;
      if (state == mip_pkg::S_FIN_DEC)  origin <= 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mip_pkg::S_IDLE:     if (in_valid) state_next = mip_pkg::S_DISPATCH;
      mip_pkg::S_DISPATCH: begin
        case (st.cmd)
          mip_pkg::CMD_START_READ:
            state_next = st.scrub ? mip_pkg::S_ISSUE : mip_pkg::S_MOD_INIT;
          mip_pkg::CMD_START_WRITE:
            state_next = st.write1 ? mip_pkg::S_WRITE1 : mip_pkg::S_ISSUE;
          mip_pkg::CMD_CHILD_DONE: state_next = mip_pkg::S_IDLE;
          default:                 state_next = mip_pkg::S_SCAN_INIT;
        endcase
      end
      mip_pkg::S_ISSUE:    if (st.out_free && st.cnt_end) state_next = mip_pkg::S_IDLE;
      mip_pkg::S_WRITE1:   if (st.out_free) state_next = mip_pkg::S_IDLE;
      mip_pkg::S_MOD_INIT: state_next = mip_pkg::S_MOD;
      mip_pkg::S_MOD:      if (st.mod_last) state_next = mip_pkg::S_SEL_INIT;
      mip_pkg::S_SEL_INIT: state_next = mip_pkg::S_SEL1;
      mip_pkg::S_SEL1: begin
        if (st.hit1) state_next = mip_pkg::S_EMIT_SEL;
        else if (st.cnt_end)
          state_next = st.no_sibling ? mip_pkg::S_SEL2 : mip_pkg::S_SEL_FAIL;
      end
      mip_pkg::S_SEL2: begin
        if (st.hit2) state_next = mip_pkg::S_EMIT_SEL;
        else if (st.cnt_end) state_next = mip_pkg::S_SEL_FAIL;
      end
      mip_pkg::S_SEL_FAIL:
        state_next = origin ? mip_pkg::S_FIN_TAIL : mip_pkg::S_SCAN_INIT;
      mip_pkg::S_EMIT_SEL:  if (st.out_free) state_next = mip_pkg::S_IDLE;
      mip_pkg::S_SCAN_INIT: state_next = mip_pkg::S_SCAN;
      mip_pkg::S_SCAN:      if (st.cnt_end) state_next = mip_pkg::S_FIN_DEC;
      mip_pkg::S_FIN_DEC:
        state_next = st.retry ? mip_pkg::S_MOD_INIT : mip_pkg::S_FIN_TAIL;
      mip_pkg::S_FIN_TAIL:
        state_next = st.repair_go ? mip_pkg::S_REPAIR : mip_pkg::S_DONE;
      mip_pkg::S_REPAIR:
        if ((!st.rep_qual || st.out_free) && st.cnt_end) state_next = mip_pkg::S_DONE;
      mip_pkg::S_DONE:      if (st.out_free) state_next = mip_pkg::S_IDLE;
      default:              state_next = mip_pkg::S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    op       = mip_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      mip_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = mip_pkg::OP_LOAD;
      end
      mip_pkg::S_DISPATCH:
        if (st.cmd == mip_pkg::CMD_CHILD_DONE) op = mip_pkg::OP_CHILD_UPD;
      mip_pkg::S_ISSUE:     if (st.out_free) op = mip_pkg::OP_ISSUE;
      mip_pkg::S_WRITE1:    if (st.out_free) op = mip_pkg::OP_WRITE1;
      mip_pkg::S_MOD_INIT:  op = mip_pkg::OP_MOD_INIT;
      mip_pkg::S_MOD:       op = mip_pkg::OP_MOD_STEP;
      mip_pkg::S_SEL_INIT:  op = mip_pkg::OP_SEL_INIT;
      mip_pkg::S_SEL1:      op = mip_pkg::OP_SEL1;
      mip_pkg::S_SEL2:      op = mip_pkg::OP_SEL2;
      mip_pkg::S_EMIT_SEL:  if (st.out_free) op = mip_pkg::OP_EMIT_SEL;
      mip_pkg::S_SCAN_INIT: op = mip_pkg::OP_SCAN_INIT;
      mip_pkg::S_SCAN:      op = mip_pkg::OP_SCAN;
      mip_pkg::S_REPAIR:    if (!st.rep_qual || st.out_free) op = mip_pkg::OP_REPAIR;
      mip_pkg::S_DONE:      if (st.out_free) op = mip_pkg::OP_EMIT_DONE;
      default:              op = mip_pkg::OP_NONE;
    endcase
  end

endmodule

[design/mip_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_dp
// Datapath: config, per-child map, rotation remainder, scan and result register.
// ----------------------------------------------------------------------------
module mip_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  mip_in_if.sink              in_ch,
  mip_out_if.source           out_ch,
  input  mip_pkg::op_t        op,
  output mip_pkg::dp_status_t st
);

  localparam logic [3:0] LANES_C = 4'(mip_pkg::LANES);

  // configuration
  logic [3:0] child_count;
  logic       replacing_mode, no_sibling_replicas, repair_enabled;

  // request and latched item
  logic [mip_pkg::OFFSET_W-1:0] req_offset;
  logic       req_is_write, req_resilver;
  logic [1:0] lat_cmd;
  logic       lat_scrub;
  logic [7:0] lat_dead, lat_stale;
  logic [2:0] lat_child, lat_error;

  // per-child map
  logic [2:0] child_err     [mip_pkg::LANES];
  logic       child_tried   [mip_pkg::LANES];
  logic       child_skipped [mip_pkg::LANES];

  // walk and selection
  logic [mip_pkg::IDX_W-1:0] cnt, pos, sel;
  logic [mip_pkg::MOD_BITS-1:0] msr;
  logic [mip_pkg::MCNT_W-1:0]   mcnt;
  logic [2:0] rem;

  // scan accumulators
  logic [3:0] good, nerr;
  logic       unexp;
  logic [2:0] agg;

  logic       out_valid;
  logic [3:0] lanes;
  logic [3:0] rem_sh;
  logic       pos_end, emit;
  logic [2:0] fin_status, err_clamped;

  // active lanes: zero acts as one, saturate at the lane limit
  always_comb begin
    if (child_count == 4'd0)        lanes = 4'd1;
    else if (child_count > LANES_C) lanes = LANES_C;
    else                            lanes = child_count;
  end

  assign rem_sh      = {rem, msr[mip_pkg::MOD_BITS-1]};
  assign pos_end     = ({1'b0, pos} == lanes - 4'd1);
  assign err_clamped = (lat_error > mip_pkg::ERR_OTHER) ? mip_pkg::ERR_OTHER : lat_error;
  assign fin_status  = (good != 4'd0) ? mip_pkg::ERR_OK :
                       (agg == mip_pkg::ERR_OK) ? mip_pkg::ERR_IO : agg;
  assign emit = (op == mip_pkg::OP_ISSUE) || (op == mip_pkg::OP_WRITE1) ||
                (op == mip_pkg::OP_EMIT_SEL) || (op == mip_pkg::OP_EMIT_DONE) ||
                ((op == mip_pkg::OP_REPAIR) && st.rep_qual);

  // status toward the sequencer
  always_comb begin
    st.cmd        = lat_cmd;
    st.scrub      = lat_scrub;
    st.write1     = req_resilver && replacing_mode && !lat_stale[0];
    st.cnt_end    = ({1'b0, cnt} == lanes - 4'd1);
    st.mod_last   = (mcnt == mip_pkg::MCNT_W'(mip_pkg::MOD_BITS - 1));
    st.hit1       = !child_tried[pos] && !child_skipped[pos] && !lat_dead[pos] &&
                    !lat_stale[pos];
    st.hit2       = !child_tried[cnt];
    st.no_sibling = no_sibling_replicas;
    st.retry      = !req_is_write && (good == 4'd0);
    st.repair_go  = !req_is_write && (good != 4'd0) && repair_enabled &&
                    (unexp || req_resilver);
    st.rep_qual   = (child_err[cnt] != mip_pkg::ERR_OK) ||
                    (!child_tried[cnt] && lat_stale[cnt]);
    st.out_free   = !out_valid || out_ch.ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      child_count         <= 4'd2;
      replacing_mode      <= 1'b0;
      no_sibling_replicas <= 1'b1;
      repair_enabled      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        mip_pkg::CFG_CHILD_COUNT: child_count         <= cfg_data;
        mip_pkg::CFG_REPLACING:   replacing_mode      <= cfg_data[0];
        mip_pkg::CFG_NO_SIBLING:  no_sibling_replicas <= cfg_data[0];
        mip_pkg::CFG_REPAIR_EN:   repair_enabled      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request state and child map
  always_ff @(posedge clk) begin
    if (rst) begin
      req_offset   <= '0;
      req_is_write <= 1'b0;
      req_resilver <= 1'b0;
      for (int i = 0; i < mip_pkg::LANES; i++) begin
        child_err[i]     <= mip_pkg::ERR_OK;
        child_tried[i]   <= 1'b0;
        child_skipped[i] <= 1'b0;
      end
    end else begin
      case (op)
        mip_pkg::OP_LOAD: begin
          if (in_ch.command == mip_pkg::CMD_START_READ ||
              in_ch.command == mip_pkg::CMD_START_WRITE) begin
            req_offset   <= in_ch.offset;
            req_is_write <= (in_ch.command == mip_pkg::CMD_START_WRITE);
            req_resilver <= in_ch.resilver;
            for (int i = 0; i < mip_pkg::LANES; i++) begin
              child_err[i]     <= mip_pkg::ERR_OK;
              child_tried[i]   <= 1'b0;
              child_skipped[i] <= 1'b0;
            end
          end
        end
        mip_pkg::OP_CHILD_UPD: begin
          if ({1'b0, lat_child} < lanes) begin
            child_err[lat_child]     <= err_clamped;
            child_tried[lat_child]   <= 1'b1;
            child_skipped[lat_child] <= 1'b0;
          end
        end
        mip_pkg::OP_SEL1: begin
          if (!child_tried[pos] && !child_skipped[pos]) begin
            if (lat_dead[pos]) begin
              child_err[pos]     <= mip_pkg::ERR_NODEV;
              child_tried[pos]   <= 1'b1;
              child_skipped[pos] <= 1'b1;
            end else if (lat_stale[pos]) begin
              child_err[pos]     <= mip_pkg::ERR_STALE;
              child_skipped[pos] <= 1'b1;
            end
          end
        end
        mip_pkg::OP_REPAIR: begin
          if (child_err[cnt] == mip_pkg::ERR_OK && st.rep_qual)
            child_err[cnt] <= mip_pkg::ERR_STALE;
        end
        default: ;
      endcase
    end
  end

  // item latch, walk counter, remainder unit, selection, scan
  always_ff @(posedge clk) begin
    case (op)
      mip_pkg::OP_LOAD: begin
        lat_cmd   <= in_ch.command;
        lat_scrub <= in_ch.scrub;
        lat_dead  <= in_ch.dead_mask;
        lat_stale <= in_ch.stale_mask;
        lat_child <= in_ch.child;
        lat_error <= in_ch.child_error;
        cnt       <= '0;
      end
      mip_pkg::OP_MOD_INIT: begin
        msr  <= req_offset[mip_pkg::OFFSET_W-1:mip_pkg::ROTATE_SHIFT];
        rem  <= '0;
        mcnt <= '0;
      end
      mip_pkg::OP_MOD_STEP: begin
        msr  <= {msr[mip_pkg::MOD_BITS-2:0], 1'b0};
        mcnt <= mcnt + 1'b1;
        rem  <= (rem_sh >= lanes) ? 3'(rem_sh - lanes) : rem_sh[2:0];
      end
      mip_pkg::OP_SEL_INIT: begin
        pos <= replacing_mode ? '0 : rem;
        cnt <= '0;
      end
      mip_pkg::OP_SEL1: begin
        if (st.hit1) sel <= pos;
        pos <= pos_end ? '0 : pos + 1'b1;
        cnt <= st.cnt_end ? '0 : cnt + 1'b1;
      end
      mip_pkg::OP_SEL2: begin
        if (st.hit2) sel <= cnt;
        cnt <= st.cnt_end ? '0 : cnt + 1'b1;
      end
      mip_pkg::OP_SCAN_INIT: begin
        cnt   <= '0;
        good  <= '0;
        nerr  <= '0;
        unexp <= 1'b0;
        agg   <= mip_pkg::ERR_OK;
      end
      mip_pkg::OP_SCAN: begin
        if (child_tried[cnt] && child_err[cnt] == mip_pkg::ERR_OK) begin
          good <= good + 1'b1;
        end else if (child_err[cnt] != mip_pkg::ERR_OK) begin
          if (agg != mip_pkg::ERR_IO) agg <= child_err[cnt];
          if (!child_skipped[cnt]) unexp <= 1'b1;
          nerr <= nerr + 1'b1;
        end
        cnt <= st.cnt_end ? '0 : cnt + 1'b1;
      end
      mip_pkg::OP_ISSUE, mip_pkg::OP_REPAIR:
        cnt <= st.cnt_end ? '0 : cnt + 1'b1;
      default: ;
    endcase
  end

  // result register: hold until taken, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.status       <= mip_pkg::ERR_OK;
      out_ch.error_count  <= 4'd0;
      out_ch.target_child <= cnt;
      out_ch.last         <= 1'b1;
      case (op)
        mip_pkg::OP_ISSUE: begin
          out_ch.kind <= (lat_cmd == mip_pkg::CMD_START_READ) ? mip_pkg::K_READ
                                                               : mip_pkg::K_WRITE;
          out_ch.last <= st.cnt_end;
        end
        mip_pkg::OP_WRITE1: begin
          out_ch.kind         <= mip_pkg::K_WRITE;
          out_ch.target_child <= 3'(lanes - 4'd1);
        end
        mip_pkg::OP_EMIT_SEL: begin
          out_ch.kind         <= mip_pkg::K_READ;
          out_ch.target_child <= sel;
        end
        mip_pkg::OP_REPAIR: begin
          out_ch.kind <= mip_pkg::K_REPAIR;
          out_ch.last <= 1'b0;
        end
        default: begin
          out_ch.kind         <= mip_pkg::K_DONE;
          out_ch.target_child <= 3'd0;
          out_ch.status       <= fin_status;
          out_ch.error_count  <= nerr;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid;

  // a result is only loaded when the register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ch.ready))
    else $error("result loaded over a pending result");

  // a completion in range marks its child tried
  a_child_mark: assert property (@(posedge clk) disable iff (rst)
    (op == mip_pkg::OP_CHILD_UPD && {1'b0, lat_child} < lanes) |=>
    child_tried[$past(lat_child)])
    else $error("child completion not recorded");

  // rotation remainder stays below the lane count while it is built
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (op == mip_pkg::OP_MOD_STEP) |=> ({1'b0, rem} < lanes))
    else $error("rotation remainder out of range");

endmodule

[design/mirror_io_policy_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_io_policy_unit
// RAID-1 request policy: read selection, write fan-out, completion and repair.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. The input is ready only while the
// sequencer is idle, and results leave through a one-deep output register.
// A child completion only updates the child map. A write start issues to
// the last copy only, or to every copy, as does a scrub read. A normal read
// start runs (offset >> 23) mod the active child count through a bit-serial
// remainder unit: a setup step and 41 steps. It then walks the children one
// per cycle, with a second pass when the first pass finds nothing and the
// no-sibling setting is set. A finish scans the active children, then walks
// them again when repairs are issued; a finish that finds no good copy of a
// read retries the selection. A read start that finds no child runs the
// finish path, selection included. A result that waits on the output holds
// the sequencer until it is taken.
module mirror_io_policy_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data,
  mip_in_if.sink     in_ch,
  mip_out_if.source  out_ch
);

  mip_pkg::op_t        op;
  mip_pkg::dp_status_t st;
  logic                ready;

  assign in_ch.ready = ready;

  // sequencer
  mip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .st       (st),
    .op       (op)
  );

  // datapath
  mip_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .op        (op),
    .st        (st)
  );

endmodule

[dv/mirror_io_policy_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_io_policy_checker
// Watches the request and result channels of the mirror policy unit, keeps
// its own copy of the per-child map and configuration, predicts the results
// of each accepted request transaction and compares them in order.
// ----------------------------------------------------------------------------
module mirror_io_policy_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data,
  mip_in_if.sink     in_ch,
  mip_out_if.sink    out_ch,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] target_child;
    logic [2:0] status;
    logic [3:0] error_count;
    logic       last;
  } policy_result_t;

  policy_result_t expected_results[$];

  logic [2:0]  map_err[8];
  logic        map_tried[8];
  logic        map_skipped[8];
  logic [63:0] open_offset;
  logic        open_write;
  logic        open_resilver;
  logic [3:0]  copies_cfg;
  logic        replacing_cfg;
  logic        no_sibling_cfg;
  logic        repair_cfg;

  function automatic int active_copies();
    int n;
    n = copies_cfg;
    if (n < 1) n = 1;
    if (n > mip_pkg::LANES) n = mip_pkg::LANES;
    return n;
  endfunction

  function automatic void clear_child_map();
    for (int i = 0; i < 8; i++) begin
      map_err[i] = mip_pkg::ERR_OK;
      map_tried[i] = 1'b0;
      map_skipped[i] = 1'b0;
    end
  endfunction

  function automatic void push_result(logic [1:0] kind, int tgt, logic [2:0] st,
                                     int ec);
    policy_result_t r;
    r.kind = kind;
    r.target_child = tgt[2:0];
    r.status = st;
    r.error_count = ec[3:0];
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Pick a readable child, marking dead and stale ones on the way; -1 if none.
  function automatic int pick_read_child(logic [7:0] dead, logic [7:0] stale);
    int n;
    int c;
    n = active_copies();
    c = int'((open_offset >> mip_pkg::ROTATE_SHIFT) % 64'(n));
    if (replacing_cfg) c = 0;
    for (int i = 0; i < n; i++, c++) begin
      if (c >= n) c = 0;
      if (map_tried[c] || map_skipped[c]) continue;
      if (dead[c]) begin
        map_err[c] = mip_pkg::ERR_NODEV;
        map_tried[c] = 1'b1;
        map_skipped[c] = 1'b1;
        continue;
      end
      if (!stale[c]) return c;
      map_err[c] = mip_pkg::ERR_STALE;
      map_skipped[c] = 1'b1;
    end
    if (no_sibling_cfg) begin
      for (c = 0; c < n; c++) if (!map_tried[c]) return c;
    end
    return -1;
  endfunction

  // Count good copies, aggregate errors, then retry, repair or complete.
  function automatic void close_request(logic [7:0] dead, logic [7:0] stale);
    int n;
    int good;
    int unexpected;
    int nerr;
    int s;
    logic [2:0] st;
    n = active_copies();
    good = 0;
    unexpected = 0;
    nerr = 0;
    st = mip_pkg::ERR_OK;
    for (int c = 0; c < n; c++) begin
      if (map_tried[c] && map_err[c] == mip_pkg::ERR_OK) begin
        good++;
        continue;
      end
      if (map_err[c] != mip_pkg::ERR_OK) begin
        if (st != mip_pkg::ERR_IO) st = map_err[c];
        if (!map_skipped[c]) unexpected++;
        nerr++;
      end
    end
    if (!open_write && good == 0) begin
      s = pick_read_child(dead, stale);
      if (s >= 0) begin
        push_result(mip_pkg::K_READ, s, mip_pkg::ERR_OK, 0);
        return;
      end
    end
    if (good != 0) st = mip_pkg::ERR_OK;
    else if (st == mip_pkg::ERR_OK) st = mip_pkg::ERR_IO;
    if (!open_write && good != 0 && repair_cfg && (unexpected != 0 || open_resilver)) begin
      for (int c = 0; c < n; c++) begin
        if (map_err[c] == mip_pkg::ERR_OK) begin
          if (map_tried[c] || !stale[c]) continue;
          map_err[c] = mip_pkg::ERR_STALE;
        end
        push_result(mip_pkg::K_REPAIR, c, mip_pkg::ERR_OK, 0);
      end
    end
    push_result(mip_pkg::K_DONE, 0, st, nerr);
  endfunction

  function automatic void predict_request();
    int n;
    int s;
    int before_size;
    logic [2:0] e;
    n = active_copies();
    before_size = expected_results.size();
    if (in_ch.command == mip_pkg::CMD_START_READ ||
        in_ch.command == mip_pkg::CMD_START_WRITE) begin
      clear_child_map();
      open_offset = in_ch.offset;
      open_write = (in_ch.command == mip_pkg::CMD_START_WRITE);
      open_resilver = in_ch.resilver;
    end
    case (in_ch.command)
      mip_pkg::CMD_START_READ: begin
        if (in_ch.scrub) begin
          for (int c = 0; c < n; c++) push_result(mip_pkg::K_READ, c, mip_pkg::ERR_OK, 0);
        end else begin
          s = pick_read_child(in_ch.dead_mask, in_ch.stale_mask);
          if (s >= 0) push_result(mip_pkg::K_READ, s, mip_pkg::ERR_OK, 0);
          else close_request(in_ch.dead_mask, in_ch.stale_mask);
        end
      end
      mip_pkg::CMD_START_WRITE: begin
        if (open_resilver && replacing_cfg && !in_ch.stale_mask[0]) begin
          push_result(mip_pkg::K_WRITE, n - 1, mip_pkg::ERR_OK, 0);
        end else begin
          for (int c = 0; c < n; c++) push_result(mip_pkg::K_WRITE, c, mip_pkg::ERR_OK, 0);
        end
      end
      mip_pkg::CMD_CHILD_DONE: begin
        e = (in_ch.child_error > mip_pkg::ERR_OTHER) ? mip_pkg::ERR_OTHER
                                                     : in_ch.child_error;
        if (int'(in_ch.child) < n) begin
          map_err[in_ch.child] = e;
          map_tried[in_ch.child] = 1'b1;
          map_skipped[in_ch.child] = 1'b0;
        end
      end
      default: close_request(in_ch.dead_mask, in_ch.stale_mask);
    endcase
    if (expected_results.size() > before_size)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // Track configuration, predict on requests, compare on results.
  always @(posedge clk) begin
    policy_result_t want;
    policy_result_t got;
    if (rst) begin
      clear_child_map();
      open_offset = '0;
      open_write = 1'b0;
      open_resilver = 1'b0;
      copies_cfg = 4'd2;
      replacing_cfg = 1'b0;
      no_sibling_cfg = 1'b1;
      repair_cfg = 1'b1;
      fail_count <= 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mip_pkg::CFG_CHILD_COUNT: copies_cfg = cfg_data;
          mip_pkg::CFG_REPLACING:   replacing_cfg = cfg_data[0];
          mip_pkg::CFG_NO_SIBLING:  no_sibling_cfg = cfg_data[0];
          mip_pkg::CFG_REPAIR_EN:   repair_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.target_child, out_ch.status, out_ch.error_count,
               out_ch.last};
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: kind=%0d child=%0d status=%0d errs=%0d last=%0b",
                     got.kind, got.target_child, got.status, got.error_count, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: exp kind=%0d child=%0d status=%0d errs=%0d last=%0b, got kind=%0d child=%0d status=%0d errs=%0d last=%0b",
                       want.kind, want.target_child, want.status, want.error_count,
                       want.last, got.kind, got.target_child, got.status,
                       got.error_count, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_request();
      pending <= expected_results.size();
    end
  end

endmodule

[dv/mirror_io_policy_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_io_policy_unit_tb
// Drives request transactions and register settings into the mirror policy
// unit with random gaps and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module mirror_io_policy_unit_tb;

  localparam int IDLE_LIMIT = 20000;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;
  int         fail_count;
  int         pending;
  int         idle_cycles;

  mip_in_if  in_ch ();
  mip_out_if out_ch ();

  mirror_io_policy_unit u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  mirror_io_policy_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side: a random hold per result, with calm stretches.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (hold > 0) begin
          out_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one transaction and hold it until taken; valid drops on the
  // next gap or drain.
  task automatic send_request(logic [1:0] cmd, logic scrub, logic resilver,
                              logic [63:0] offset, logic [7:0] dead,
                              logic [7:0] stale, logic [2:0] child,
                              logic [2:0] err);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.scrub <= scrub;
    in_ch.resilver <= resilver;
    in_ch.offset <= offset;
    in_ch.dead_mask <= dead;
    in_ch.stale_mask <= stale;
    in_ch.child <= child;
    in_ch.child_error <= err;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [63:0] random_offset();
    return {$urandom(), $urandom()};
  endfunction

  // Let the block drain, including work on items that give no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [3:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed request: start, completions with random errors, finish.
  task automatic random_request();
    logic [1:0] start;
    logic [7:0] dead;
    logic [7:0] stale;
    int done_count;
    start = $urandom_range(0, 1) ? mip_pkg::CMD_START_WRITE : mip_pkg::CMD_START_READ;
    dead = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
    stale = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
    send_request(start, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                 random_offset(), dead, stale, 3'($urandom), 3'($urandom));
    done_count = $urandom_range(0, 3);
    for (int i = 0; i < done_count; i++)
      send_request(mip_pkg::CMD_CHILD_DONE, 1'($urandom), 1'($urandom), random_offset(),
                   dead, stale, 3'($urandom),
                   ($urandom_range(0, 1) == 0) ? mip_pkg::ERR_OK : 3'($urandom));
    send_request(mip_pkg::CMD_FINISH, 1'($urandom), 1'($urandom), random_offset(), dead,
                 stale, 3'($urandom), 3'($urandom));
    if ($urandom_range(0, 2) == 0)
      send_request(mip_pkg::CMD_FINISH, 1'($urandom), 1'($urandom), random_offset(),
                   8'($urandom), 8'($urandom), 3'($urandom), 3'($urandom));
  endtask

  initial begin
    logic [3:0] counts[6];
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = mip_pkg::CFG_CHILD_COUNT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = mip_pkg::CMD_START_READ;
    in_ch.scrub = 1'b0;
    in_ch.resilver = 1'b0;
    in_ch.offset = '0;
    in_ch.dead_mask = '0;
    in_ch.stale_mask = '0;
    in_ch.child = '0;
    in_ch.child_error = mip_pkg::ERR_OK;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every command, stray items, all-dead read start.
    write_register(mip_pkg::CFG_CHILD_COUNT, 4'd8);
    send_request(mip_pkg::CMD_FINISH, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd0,
                 mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_CHILD_DONE, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd7, 3'd7);
    send_request(mip_pkg::CMD_START_READ, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
                 8'hFF, 3'd7, 3'd7);
    send_request(mip_pkg::CMD_CHILD_DONE, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd3, 3'd6);
    send_request(mip_pkg::CMD_CHILD_DONE, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd5,
                 mip_pkg::ERR_IO);
    send_request(mip_pkg::CMD_FINISH, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd0,
                 mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_START_READ, 1'b0, 1'b0, 64'h0000_0000_0180_0000, 8'hFF,
                 8'h00, 3'd0, mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_START_READ, 1'b0, 1'b1, 64'h0000_0000_0380_0000, 8'h0F,
                 8'hF0, 3'd0, mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_CHILD_DONE, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd4, 3'd4);
    send_request(mip_pkg::CMD_FINISH, 1'b0, 1'b0, '0, 8'h0F, 8'hF0, 3'd0,
                 mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_START_WRITE, 1'b0, 1'b1, '0, 8'h00, 8'h00, 3'd0,
                 mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_FINISH, 1'b0, 1'b0, '0, 8'h00, 8'h00, 3'd0,
                 mip_pkg::ERR_OK);
    drain();
    write_register(mip_pkg::CFG_REPLACING, 4'd1);
    write_register(mip_pkg::CFG_NO_SIBLING, 4'd0);
    write_register(mip_pkg::CFG_REPAIR_EN, 4'd0);
    write_register(mip_pkg::CFG_CHILD_COUNT, 4'd15);
    send_request(mip_pkg::CMD_START_WRITE, 1'b0, 1'b1, '0, 8'h00, 8'h00, 3'd0,
                 mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_START_WRITE, 1'b0, 1'b1, '0, 8'h00, 8'h01, 3'd0,
                 mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_START_READ, 1'b0, 1'b0, 64'h1234_5678_9ABC_DEF0, 8'h01,
                 8'h02, 3'd0, mip_pkg::ERR_OK);
    send_request(mip_pkg::CMD_START_READ, 1'b0, 1'b0, '0, 8'hAA, 8'h55, 3'd0,
                 mip_pkg::ERR_OK);
    drain();

    // Random requests over several register settings.
    for (int phase = 0; phase < 6; phase++) begin
      write_register(mip_pkg::CFG_CHILD_COUNT, counts[phase]);
      write_register(mip_pkg::CFG_REPLACING, 4'($urandom_range(0, 1)));
      write_register(mip_pkg::CFG_NO_SIBLING, 4'($urandom_range(0, 1)));
      write_register(mip_pkg::CFG_REPAIR_EN, 4'($urandom_range(0, 3) != 0));
      for (int i = 0; i < 22; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_request(2'($urandom), 1'($urandom), 1'($urandom), random_offset(),
                       8'($urandom), 8'($urandom), 3'($urandom), 3'($urandom));
        else
          random_request();
      end
      drain();
    end
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
